FILE: hdl/ssfp_pkg.sv
// Shared types, constants and offset decode for the sensor stream frame parser.
`timescale 1ns / 1ps

package ssfp_pkg;

	localparam logic [7:0] HDR_BYTE    = 8'd19;
	localparam logic [7:0] MIN_PAYLOAD = 8'd52;
	localparam int         NUM_WORDS   = 8;
	localparam int         SLOT_W      = $clog2(NUM_WORDS);
	localparam int         FLAG_W      = 13;
	localparam int         QUEUE_DEPTH = 2;
	localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int         QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Payload offsets of status bytes
	localparam logic [7:0] OFF_BUMP    = 8'd0;
	localparam logic [7:0] OFF_FLAG_LO = 8'd1;
	localparam logic [7:0] OFF_FLAG_HI = 8'd6;
	localparam logic [7:0] OFF_BUTTON  = 8'd11;

	// Flag bit positions
	localparam int FLAG_BUMP_R  = 0;
	localparam int FLAG_BUMP_L  = 1;
	localparam int FLAG_PLAY    = 11;
	localparam int FLAG_ADVANCE = 12;

	// Frame status codes
	typedef enum logic [1:0] {
		STATUS_GOOD  = 2'd0,
		STATUS_CSUM  = 2'd1,
		STATUS_SHORT = 2'd2
	} status_t;

	// Parsed frame handed from the front to the back
	typedef struct packed {
		logic                    sum_ok;
		logic                    long_ok;
		logic [FLAG_W-1:0]       flags;
		logic [NUM_WORDS-1:0][15:0] words;
	} frame_rec_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} slot_hit_t;

	// Map a payload offset to the word slot whose high byte sits there
	function automatic slot_hit_t word_slot(input logic [7:0] off);
		slot_hit_t r;
		r.hit  = 1'b1;
		r.slot = '0;
		unique case (off)
			8'd12:   r.slot = SLOT_W'(0);
			8'd14:   r.slot = SLOT_W'(1);
			8'd22:   r.slot = SLOT_W'(2);
			8'd24:   r.slot = SLOT_W'(3);
			8'd44:   r.slot = SLOT_W'(4);
			8'd46:   r.slot = SLOT_W'(5);
			8'd48:   r.slot = SLOT_W'(6);
			8'd50:   r.slot = SLOT_W'(7);
			default: r.hit  = 1'b0;
		endcase
		return r;
	endfunction

endpackage

FILE: hdl/ssfp_front.sv
// Front end: frame sync, checksum, flag and word capture per received word.
`timescale 1ns / 1ps

module ssfp_front import ssfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic [7:0] rx_byte,
	output logic       rec_valid,
	output frame_rec_t rec
);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_LEN,
		PH_DATA,
		PH_SUM
	} phase_t;

	phase_t                     phase_q;
	logic [7:0]                 left_q;
	logic [7:0]                 idx_q;
	logic [7:0]                 sum_q;
	logic [7:0]                 len_q;
	logic [FLAG_W-1:0]          flags_q;
	logic [7:0]                 hold_q;
	logic [NUM_WORDS-1:0][15:0] words_q;

	logic [7:0]  sum_next;
	slot_hit_t   hi_hit;
	slot_hit_t   lo_hit;
	logic        data_fire;

	assign sum_next  = sum_q + rx_byte;
	assign hi_hit    = word_slot(idx_q);
	assign lo_hit    = word_slot(idx_q - 8'd1);
	assign data_fire = in_fire && (phase_q == PH_DATA);

	// Emit the record when the checksum word arrives
	assign rec_valid     = in_fire && (phase_q == PH_SUM);
	assign rec.sum_ok    = (sum_next == 8'd0);
	assign rec.long_ok   = (len_q >= MIN_PAYLOAD);
	assign rec.flags     = flags_q;
	assign rec.words     = words_q;

	// Advance the parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			left_q  <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
			len_q   <= '0;
			flags_q <= '0;
			hold_q  <= '0;
		end else if (in_fire) begin
			unique case (phase_q)
				PH_HUNT: begin
					if (rx_byte == HDR_BYTE) begin
						sum_q   <= HDR_BYTE;
						flags_q <= '0;
						phase_q <= PH_LEN;
					end
				end
				PH_LEN: begin
					sum_q   <= sum_next;
					left_q  <= rx_byte;
					len_q   <= rx_byte;
					idx_q   <= '0;
					phase_q <= (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
				end
				PH_DATA: begin
					sum_q  <= sum_next;
					idx_q  <= idx_q + 8'd1;
					left_q <= left_q - 8'd1;
					if (left_q == 8'd1) begin
						phase_q <= PH_SUM;
					end
					// Capture status bytes into flag bits
					if (idx_q == OFF_BUMP) begin
						flags_q[4:0] <= rx_byte[4:0];
					end else if (idx_q >= OFF_FLAG_LO && idx_q <= OFF_FLAG_HI) begin
						if (rx_byte != 8'd0) begin
							flags_q[idx_q[3:0] + 4'd4] <= 1'b1;
						end
					end else if (idx_q == OFF_BUTTON) begin
						if (rx_byte[0]) begin
							flags_q[FLAG_PLAY] <= 1'b1;
						end
						if (rx_byte[2]) begin
							flags_q[FLAG_ADVANCE] <= 1'b1;
						end
					end
					if (hi_hit.hit) begin
						hold_q <= rx_byte;
					end
				end
				PH_SUM: begin
					phase_q <= PH_HUNT;
				end
				default: phase_q <= PH_HUNT;
			endcase
		end
	end

	// Store the low half of a big-endian word with its held high half
	always_ff @(posedge clk) begin
		if (data_fire && !hi_hit.hit && idx_q != 8'd0 && lo_hit.hit) begin
			words_q[lo_hit.slot] <= {hold_q, rx_byte};
		end
	end

endmodule

FILE: hdl/ssfp_queue.sv
// Short record queue between the front and the back.
`timescale 1ns / 1ps

module ssfp_queue import ssfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  frame_rec_t wr_data,
	output logic       q_full,
	input  logic       rd_en,
	output logic       q_valid,
	output frame_rec_t rd_data
);

	frame_rec_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign q_full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_valid = (count_q != '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && q_valid;
	assign rd_data = mem_q[rd_ptr_q];

	// Hold entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/ssfp_back.sv
// Back end: status, event edge detect and the result output register.
`timescale 1ns / 1ps

module ssfp_back import ssfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  frame_rec_t          q_data,
	output logic                q_rd,
	input  logic                out_pop,
	output logic                out_valid,
	output logic [1:0]          frame_status,
	output logic [FLAG_W-1:0]   sensor_flags,
	output logic signed [15:0]  distance_mm,
	output logic signed [15:0]  angle_deg,
	output logic [15:0]         charge_raw,
	output logic [15:0]         capacity_raw,
	output logic signed [15:0]  drive_speed,
	output logic signed [15:0]  turn_radius,
	output logic signed [15:0]  right_wheel_speed,
	output logic signed [15:0]  left_wheel_speed,
	output logic                bump_event,
	output logic                play_event
);

	logic                       valid_q;
	logic                       bump_latch_q;
	logic                       play_latch_q;
	status_t                    status_q;
	logic [FLAG_W-1:0]          flags_q;
	logic [NUM_WORDS-1:0][15:0] words_q;
	logic                       bump_ev_q;
	logic                       play_ev_q;

	logic    good;
	logic    bump_now;
	logic    play_now;
	status_t status_d;

	assign q_rd     = q_valid && (!valid_q || out_pop);
	assign good     = q_data.sum_ok && q_data.long_ok;
	assign bump_now = q_data.flags[FLAG_BUMP_R] || q_data.flags[FLAG_BUMP_L];
	assign play_now = q_data.flags[FLAG_PLAY];

	// Checksum error wins over a short payload
	always_comb begin
		priority if (!q_data.sum_ok) begin
			status_d = STATUS_CSUM;
		end else if (!q_data.long_ok) begin
			status_d = STATUS_SHORT;
		end else begin
			status_d = STATUS_GOOD;
		end
	end

	// Track output occupancy and button latches
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			bump_latch_q <= 1'b0;
			play_latch_q <= 1'b0;
		end else begin
			if (q_rd) begin
				valid_q <= 1'b1;
			end else if (out_pop) begin
				valid_q <= 1'b0;
			end
			if (q_rd && good) begin
				bump_latch_q <= bump_now;
				play_latch_q <= play_now;
			end
		end
	end

	// Load result fields; zero flags, words and events on a bad frame
	always_ff @(posedge clk) begin
		if (q_rd) begin
			status_q  <= status_d;
			flags_q   <= good ? q_data.flags : '0;
			words_q   <= good ? q_data.words : '0;
			bump_ev_q <= good && bump_now && !bump_latch_q;
			play_ev_q <= good && play_now && !play_latch_q;
		end
	end

	assign out_valid         = valid_q;
	assign frame_status      = status_q;
	assign sensor_flags      = flags_q;
	assign distance_mm       = words_q[0];
	assign angle_deg         = words_q[1];
	assign charge_raw        = words_q[2];
	assign capacity_raw      = words_q[3];
	assign drive_speed       = words_q[4];
	assign turn_radius       = words_q[5];
	assign right_wheel_speed = words_q[6];
	assign left_wheel_speed  = words_q[7];
	assign bump_event        = bump_ev_q;
	assign play_event        = play_ev_q;

endmodule

FILE: hdl/sensor_stream_frame_parser_unit.sv
// Top level of the sensor stream frame parser: front, record queue, back.
// Throughput: one received word per cycle while full is low; each word is parsed in the cycle it is taken.
// A record enters the two-entry record queue when its checksum word is taken, and the
// output register takes it from the queue when that register is free.
// full follows the record queue; the output register reloads from it when empty or popped.
// Reset: arst_n clears parse state, queue and latches; captured words hold until written.
`timescale 1ns / 1ps

module sensor_stream_frame_parser_unit import ssfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         frame_status,
	output logic [12:0]        sensor_flags,
	output logic signed [15:0] distance_mm,
	output logic signed [15:0] angle_deg,
	output logic [15:0]        charge_raw,
	output logic [15:0]        capacity_raw,
	output logic signed [15:0] drive_speed,
	output logic signed [15:0] turn_radius,
	output logic signed [15:0] right_wheel_speed,
	output logic signed [15:0] left_wheel_speed,
	output logic               bump_event,
	output logic               play_event
);

	logic       in_fire;
	logic       rec_valid;
	frame_rec_t rec;
	logic       q_full;
	logic       q_valid;
	logic       q_rd;
	frame_rec_t q_data;
	logic       out_valid;

	assign full    = q_full;
	assign in_fire = push && !q_full;
	assign empty   = !out_valid;

	ssfp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.rx_byte   (rx_byte),
		.rec_valid (rec_valid),
		.rec       (rec)
	);

	ssfp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (rec_valid),
		.wr_data (rec),
		.q_full  (q_full),
		.rd_en   (q_rd),
		.q_valid (q_valid),
		.rd_data (q_data)
	);

	ssfp_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_data            (q_data),
		.q_rd              (q_rd),
		.out_pop           (pop),
		.out_valid         (out_valid),
		.frame_status      (frame_status),
		.sensor_flags      (sensor_flags),
		.distance_mm       (distance_mm),
		.angle_deg         (angle_deg),
		.charge_raw        (charge_raw),
		.capacity_raw      (capacity_raw),
		.drive_speed       (drive_speed),
		.turn_radius       (turn_radius),
		.right_wheel_speed (right_wheel_speed),
		.left_wheel_speed  (left_wheel_speed),
		.bump_event        (bump_event),
		.play_event        (play_event)
	);

endmodule

FILE: sim/ssfp_frame_checker.sv
// Frame checker for the sensor stream frame parser: predicts each record and compares it.
`timescale 1ns / 1ps

module ssfp_frame_checker import ssfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [7:0]         rx_byte,
	input  logic               empty,
	input  logic               pop,
	input  logic [1:0]         frame_status,
	input  logic [12:0]        sensor_flags,
	input  logic signed [15:0] distance_mm,
	input  logic signed [15:0] angle_deg,
	input  logic [15:0]        charge_raw,
	input  logic [15:0]        capacity_raw,
	input  logic signed [15:0] drive_speed,
	input  logic signed [15:0] turn_radius,
	input  logic signed [15:0] right_wheel_speed,
	input  logic signed [15:0] left_wheel_speed,
	input  logic               bump_event,
	input  logic               play_event,
	output int                 mismatch_count,
	output int                 frames_outstanding
);

	// Payload offsets of the high bytes of the eight words, slot 0 first
	localparam logic [NUM_WORDS-1:0][7:0] WORD_OFFSETS =
		{8'd50, 8'd48, 8'd46, 8'd44, 8'd24, 8'd22, 8'd14, 8'd12};

	typedef enum logic [1:0] {
		SEEK_HDR,
		TAKE_LEN,
		TAKE_DATA,
		TAKE_SUM
	} parse_phase_t;

	typedef struct packed {
		status_t                    status;
		logic [FLAG_W-1:0]          flags;
		logic [NUM_WORDS-1:0][15:0] words;
		logic                       bump;
		logic                       play;
	} frame_record_t;

	frame_record_t              records_due[$];
	frame_record_t              rec;
	parse_phase_t               phase;
	logic [7:0]                 remaining;
	logic [7:0]                 index;
	logic [7:0]                 csum;
	logic [7:0]                 sum_now;
	logic [7:0]                 frame_len;
	logic [7:0]                 hi_hold;
	logic [FLAG_W-1:0]          flags;
	logic [NUM_WORDS-1:0][15:0] words;
	logic                       bump_seen;
	logic                       play_seen;
	int                         slot;

	function automatic int slot_of(input logic [7:0] off);
		for (int s = 0; s < NUM_WORDS; s++)
			if (WORD_OFFSETS[s] == off)
				return s;
		return -1;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase = SEEK_HDR;
			remaining = '0;
			index = '0;
			csum = '0;
			frame_len = '0;
			hi_hold = '0;
			flags = '0;
			words = '0;
			bump_seen = 1'b0;
			play_seen = 1'b0;
			mismatch_count = 0;
			records_due.delete();
			frames_outstanding <= 0;
		end else begin
			// compare the word leaving the result side with the oldest record due
			if (pop && !empty) begin
				if (records_due.size() == 0) begin
					$error("frame_status: expected no record, got %0h", frame_status);
					mismatch_count++;
				end else begin
					rec = records_due.pop_front();
					check_field("frame_status", 16'(rec.status), 16'(frame_status));
					check_field("sensor_flags", 16'(rec.flags), 16'(sensor_flags));
					check_field("distance_mm", rec.words[0], distance_mm);
					check_field("angle_deg", rec.words[1], angle_deg);
					check_field("charge_raw", rec.words[2], charge_raw);
					check_field("capacity_raw", rec.words[3], capacity_raw);
					check_field("drive_speed", rec.words[4], drive_speed);
					check_field("turn_radius", rec.words[5], turn_radius);
					check_field("right_wheel_speed", rec.words[6], right_wheel_speed);
					check_field("left_wheel_speed", rec.words[7], left_wheel_speed);
					check_field("bump_event", 16'(rec.bump), 16'(bump_event));
					check_field("play_event", 16'(rec.play), 16'(play_event));
				end
			end

			// advance the parser on an accepted word
			if (push && !full) begin
				case (phase)
				SEEK_HDR: begin
					if (rx_byte == HDR_BYTE) begin
						csum = HDR_BYTE;
						flags = '0;
						phase = TAKE_LEN;
					end
				end
				TAKE_LEN: begin
					csum = csum + rx_byte;
					remaining = rx_byte;
					frame_len = rx_byte;
					index = '0;
					phase = (rx_byte == 8'd0) ? TAKE_SUM : TAKE_DATA;
				end
				TAKE_DATA: begin
					csum = csum + rx_byte;
					// status bytes feed the flag bits
					if (index == OFF_BUMP) begin
						flags[4:0] = rx_byte[4:0];
					end else if (index >= OFF_FLAG_LO && index <= OFF_FLAG_HI) begin
						if (rx_byte != 8'd0)
							flags[int'(index) + 4] = 1'b1;
					end else if (index == OFF_BUTTON) begin
						if (rx_byte[0])
							flags[FLAG_PLAY] = 1'b1;
						if (rx_byte[2])
							flags[FLAG_ADVANCE] = 1'b1;
					end
					// hold the high byte, then build the word on the low byte
					slot = slot_of(index);
					if (slot >= 0) begin
						hi_hold = rx_byte;
					end else if (index > 8'd0) begin
						slot = slot_of(index - 8'd1);
						if (slot >= 0)
							words[slot] = {hi_hold, rx_byte};
					end
					index = index + 8'd1;
					remaining = remaining - 8'd1;
					if (remaining == 8'd0)
						phase = TAKE_SUM;
				end
				default: begin
					// close the frame and queue its record
					rec = '0;
					sum_now = csum + rx_byte;
					phase = SEEK_HDR;
					if (sum_now != 8'd0) begin
						rec.status = STATUS_CSUM;
					end else if (frame_len < MIN_PAYLOAD) begin
						rec.status = STATUS_SHORT;
					end else begin
						rec.status = STATUS_GOOD;
						rec.flags = flags;
						rec.words = words;
						if (flags[FLAG_BUMP_R] || flags[FLAG_BUMP_L]) begin
							rec.bump = !bump_seen;
							bump_seen = 1'b1;
						end else begin
							bump_seen = 1'b0;
						end
						if (flags[FLAG_PLAY]) begin
							rec.play = !play_seen;
							play_seen = 1'b1;
						end else begin
							play_seen = 1'b0;
						end
					end
					records_due = {records_due, rec};
				end
				endcase
			end
			frames_outstanding <= records_due.size();
		end
	end

endmodule

FILE: sim/tb_sensor_stream_frame_parser_unit.sv
// Testbench top for the sensor stream frame parser: clock, reset, byte stream and verdict.
`timescale 1ns / 1ps

module tb_sensor_stream_frame_parser_unit;
	import ssfp_pkg::*;

	localparam int RAND_ITEMS     = 660;
	localparam int RAND_FRAMES    = 3;
	localparam int CALM_FRAMES    = 1;
	localparam int HOLD_OFF_LEN   = 200;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int TAIL_CYCLES    = 10;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         rx_byte;
	logic               empty;
	logic               pop;
	logic [1:0]         frame_status;
	logic [12:0]        sensor_flags;
	logic signed [15:0] distance_mm;
	logic signed [15:0] angle_deg;
	logic [15:0]        charge_raw;
	logic [15:0]        capacity_raw;
	logic signed [15:0] drive_speed;
	logic signed [15:0] turn_radius;
	logic signed [15:0] right_wheel_speed;
	logic signed [15:0] left_wheel_speed;
	logic               bump_event;
	logic               play_event;
	int                 mismatch_count;
	int                 frames_outstanding;

	logic [7:0]         payload [256];
	int                 items_sent = 0;
	int                 frames_sent = 0;
	bit                 sender_idle_on = 1'b0;
	bit                 calm = 1'b0;
	bit                 hold_off_req = 1'b0;
	bit                 hold_off_active = 1'b0;

	sensor_stream_frame_parser_unit i_dut (.*);

	ssfp_frame_checker i_checker (.*);

	always #10 clk = ~clk;

	// Offer one word until it is taken, then maybe idle for a burst
	task automatic send_byte(input logic [7:0] b, input bit counted);
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		if (counted)
			items_sent++;
		if (sender_idle_on && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// Send header, length, payload and a checksum, broken on request
	task automatic send_frame(input int len, input bit corrupt);
		logic [7:0] sum;
		logic [7:0] csum;
		sum = HDR_BYTE + 8'(len);
		send_byte(HDR_BYTE, 1'b1);
		send_byte(8'(len), 1'b1);
		for (int i = 0; i < len; i++) begin
			sum = sum + payload[i];
			send_byte(payload[i], 1'b1);
		end
		csum = 8'd0 - sum;
		if (corrupt)
			csum = csum + 8'($urandom_range(1, 255));
		send_byte(csum, 1'b1);
		frames_sent++;
	endtask

	// Random payload; status bytes are often clear so the edge events toggle
	task automatic fill_payload(input int len);
		for (int i = 0; i < len; i++) begin
			payload[i] = 8'($urandom_range(0, 255));
			if ((i <= 6 || i == 11) && $urandom_range(0, 1) == 1)
				payload[i] = 8'h00;
		end
	endtask

	// Zero the payload and put the most negative and most positive words in turn
	task automatic set_extreme_words(input bit swap);
		slot_hit_t sh;
		foreach (payload[i])
			payload[i] = 8'h00;
		for (int i = 0; i < 52; i++) begin
			sh = word_slot(8'(i));
			if (sh.hit) begin
				payload[i] = (sh.slot[0] ^ swap) ? 8'h80 : 8'h7f;
				payload[i + 1] = (sh.slot[0] ^ swap) ? 8'h00 : 8'hff;
			end
		end
	endtask

	// Idle the input and wait for every record due, within a limit
	task automatic drain(output bit ok);
		int waited;
		waited = 0;
		push <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (frames_outstanding != 0 && waited < DRAIN_LIMIT);
		ok = (frames_outstanding == 0);
	endtask

	// Result side: random pop bursts, one long hold-off, steady pop at the end
	initial begin
		int n;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req && !hold_off_active) begin
				pop <= 1'b0;
				n = HOLD_OFF_LEN;
				hold_off_active = 1'b1;
			end else if (calm || $urandom_range(0, 2) != 0) begin
				pop <= 1'b1;
				n = $urandom_range(1, 30);
			end else begin
				pop <= 1'b0;
				n = $urandom_range(1, 14);
			end
			repeat (n) @(posedge clk);
		end
	end

	// Stimulus and verdict
	initial begin
		int         r;
		int         len;
		int         cut;
		int         rand_frames;
		logic [7:0] b;
		bit         drained_mid;
		bit         drained_end;

		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = 8'h00;
		drained_mid = 1'b0;
		foreach (payload[i])
			payload[i] = 8'h00;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored line noise before the first header
		send_byte(8'h00, 1'b0);
		send_byte(8'hff, 1'b0);
		send_byte(8'd18, 1'b0);
		send_byte(8'd20, 1'b0);
		// empty payload: good sum reads as short, bad sum as checksum error
		send_frame(0, 1'b0);
		send_frame(0, 1'b1);
		// one byte short of a full record
		fill_payload(51);
		send_frame(51, 1'b0);
		// all-zero and all-one payloads; the repeat must not fire events again
		foreach (payload[i])
			payload[i] = 8'h00;
		send_frame(52, 1'b0);
		foreach (payload[i])
			payload[i] = 8'hff;
		send_frame(52, 1'b0);
		send_frame(52, 1'b0);
		// a bad frame leaves the latches alone, a clear one releases them
		send_frame(52, 1'b1);
		foreach (payload[i])
			payload[i] = 8'h00;
		send_frame(52, 1'b0);
		// word extremes with single bump and button bits
		set_extreme_words(1'b0);
		payload[0] = 8'h01;
		payload[11] = 8'h04;
		send_frame(52, 1'b0);
		set_extreme_words(1'b1);
		payload[0] = 8'h02;
		payload[3] = 8'h01;
		payload[11] = 8'h01;
		send_frame(52, 1'b0);
		// drop bits only: bumpers released
		payload[0] = 8'h1c;
		payload[11] = 8'h00;
		send_frame(52, 1'b0);
		// payload longer than the record needs; the tail only counts in the sum
		fill_payload(80);
		send_frame(80, 1'b0);

		rand_frames = 0;
		while (items_sent < RAND_ITEMS || rand_frames < RAND_FRAMES) begin
			sender_idle_on = ($urandom_range(0, 2) != 0);
			if (rand_frames == 0) begin
				// stall the result side and keep offering short frames until full
				sender_idle_on = 1'b0;
				hold_off_req = 1'b1;
				push <= 1'b0;
				wait (hold_off_active);
				@(posedge clk);
				repeat (12)
					send_frame(0, 1'(($urandom_range(0, 1))));
			end
			if (rand_frames == 1)
				drain(drained_mid);
			r = $urandom_range(0, 99);
			if (r < 68) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(53, 255)
					: $urandom_range(52, 56);
				fill_payload(len);
				send_frame(len, 1'b0);
			end else if (r < 78) begin
				len = $urandom_range(0, 80);
				fill_payload(len);
				send_frame(len, 1'b1);
			end else if (r < 88) begin
				len = $urandom_range(0, 51);
				fill_payload(len);
				send_frame(len, 1'b0);
			end else if (r < 94) begin
				// cut a frame short; its tail swallows whatever follows
				len = $urandom_range(52, 56);
				cut = $urandom_range(0, len - 1);
				fill_payload(len);
				send_byte(HDR_BYTE, 1'b1);
				send_byte(8'(len), 1'b1);
				for (int i = 0; i < cut; i++)
					send_byte(payload[i], 1'b1);
			end else begin
				// line noise between frames
				repeat ($urandom_range(1, 6)) begin
					b = 8'($urandom_range(0, 255));
					if (b == HDR_BYTE)
						b = ~b;
					send_byte(b, 1'b0);
				end
			end
			rand_frames++;
		end

		// last stretch: no idling on either side
		calm = 1'b1;
		sender_idle_on = 1'b0;
		repeat (CALM_FRAMES) begin
			len = $urandom_range(52, 56);
			fill_payload(len);
			send_frame(len, 1'b0);
		end

		drain(drained_end);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && drained_mid && drained_end)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Hard stop for a hung run
	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: sensor_stream_frame_parser_unit.f
hdl/ssfp_pkg.sv
hdl/ssfp_front.sv
hdl/ssfp_queue.sv
hdl/ssfp_back.sv
hdl/sensor_stream_frame_parser_unit.sv
sim/ssfp_frame_checker.sv
sim/tb_sensor_stream_frame_parser_unit.sv
